/* sv/adaptive_peak_detector_unit_assert.svh */
// ----------------------------------------------------------------------------
// Adaptive peak detector assertion macros
// Shorthand for the concurrent checks of the block, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_PEAK_DETECTOR_UNIT_ASSERT_SVH
`define ADAPTIVE_PEAK_DETECTOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define APD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("apd: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define APD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("apd: next-cycle check failed");

`endif

/* sv/apd_pkg.sv */
// ----------------------------------------------------------------------------
// Adaptive peak detector package
// Shared constants, register indexes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package apd_pkg;

  // Sliding window storage. A block average can reach 32 bits when the block
  // length is lowered under a long running count.
  localparam int WIN_DEPTH = 64;
  localparam int WIN_IDX_W = $clog2(WIN_DEPTH);
  localparam int WIN_CNT_W = $clog2(WIN_DEPTH + 1);
  localparam int AVG_W     = 32;
  localparam int WSUM_W    = AVG_W + $clog2(WIN_DEPTH);

  // Window mean times the Q8.8 factor (zero-extended to 17 bits)
  localparam int PROD_W    = AVG_W + 17;

  // Shared divider, wide enough for the window sum
  localparam int DIV_W     = WSUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_START_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AVERAGES_KEPT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SAMPLES     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DETECTION_FACTOR = 3'd4;

  // Register reset values
  localparam logic signed [15:0] START_THR_RST  = 16'sd3277;
  localparam logic [15:0]        BLOCK_LEN_RST  = 16'd2205;
  localparam logic [6:0]         AVG_KEPT_RST   = 7'd39;
  localparam logic [19:0]        HOLD_RST       = 20'd17640;
  localparam logic [15:0]        FACTOR_RST     = 16'd1536;

  // Input op codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_REARM  = 1'b1;

  typedef struct packed {
    logic latch_in;
    logic eval;
    logic div_avg;
    logic take_avg;
    logic drop;
    logic push;
    logic div_mean;
    logic take_mean;
    logic mul;
    logic sat;
    logic hold_step;
    logic load_out;
  } apd_cmd_t;

  typedef struct packed {
    logic rearm;
    logic go;
    logic close_due;
    logic div_done;
    logic div_busy;
    logic drop_due;
    logic out_free;
  } apd_sts_t;

endpackage

/* sv/apd_channels.sv */
// ----------------------------------------------------------------------------
// Adaptive peak detector channels
// Valid/ready interfaces for the sample stream and the result stream.
// ----------------------------------------------------------------------------
interface apd_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [15:0] sample;

  modport source (output valid, output op, output sample, input ready);
  modport sink   (input valid, input op, input sample, output ready);
endinterface

interface apd_out_if;
  logic valid;
  logic ready;
  logic peak;
  logic detecting;

  modport source (output valid, output peak, output detecting, input ready);
  modport sink   (input valid, input peak, input detecting, output ready);
endinterface

/* sv/apd_div.sv */
// ----------------------------------------------------------------------------
// Adaptive peak detector divider
// Signed by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module apd_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [apd_pkg::DIV_W-1:0]     dividend,
  input  logic [15:0]                          divisor,
  output logic                                 busy,
  output logic                                 done,
  output logic signed [apd_pkg::DIV_W-1:0]     quotient
);
  import apd_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [15:0]          rem_r;
  logic [DIV_W-1:0]     quo_r;
  logic [15:0]          den_r;
  logic                 neg_r;

  logic [16:0]          trial;
  logic                 fits;
  logic [15:0]          rem_nxt;
  logic [DIV_W-1:0]     mag;

  assign mag     = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
  assign trial   = {rem_r, quo_r[DIV_W-1]};
  assign fits    = trial >= {1'b0, den_r};
  assign rem_nxt = fits ? 16'(trial - {1'b0, den_r}) : trial[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      rem_r <= '0;
      quo_r <= mag;
      den_r <= divisor;
      neg_r <= dividend[DIV_W-1];
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = neg_r ? $signed(-quo_r) : $signed(quo_r);

endmodule

/* sv/apd_dp.sv */
// ----------------------------------------------------------------------------
// Adaptive peak detector datapath
// Configuration registers, block accumulator, window store and running sum,
// trigger level, hold counter and the result register.
// ----------------------------------------------------------------------------
module apd_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  apd_pkg::apd_cmd_t                  cmd,
  output apd_pkg::apd_sts_t                  sts,
  input  logic                               in_op,
  input  logic signed [15:0]                 in_sample,
  input  logic                               cfg_we,
  input  logic [apd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [apd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic                               out_peak,
  output logic                               out_detecting
);
  import apd_pkg::*;

  // Configuration
  logic signed [15:0] start_r;
  logic [15:0]        len_r;
  logic [6:0]         kept_r;
  logic [19:0]        hold_r;
  logic [15:0]        factor_r;

  // Detector state
  logic                     active_r;
  logic [15:0]              bcnt_r;
  logic signed [31:0]       bsum_r;
  logic [WIN_CNT_W-1:0]     fill_r;
  logic [WIN_IDX_W-1:0]     head_r;
  logic signed [WSUM_W-1:0] wsum_r;
  logic signed [15:0]       trig_r;
  logic                     holding_r;
  logic [19:0]              hc_r;
  logic                     close_due_r;
  logic                     out_valid_r;

  // Working registers
  logic                     op_r;
  logic signed [15:0]       s_r;
  logic signed [AVG_W-1:0]  avg_r;
  logic signed [AVG_W-1:0]  mean_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     res_peak_r;
  logic                     res_det_r;
  logic                     out_peak_r;
  logic                     out_det_r;

  // Window store
  logic [AVG_W-1:0]         win_mem [WIN_DEPTH];
  logic [AVG_W-1:0]         rd_data_r;

  logic [15:0]              len;
  logic [15:0]              bcnt_inc;
  logic                     go;
  logic [WIN_CNT_W-1:0]     keep;
  logic [WIN_IDX_W-1:0]     wr_idx;
  logic [19:0]              hc_inc;
  logic signed [PROD_W-1:0] prod_shr;
  logic signed [PROD_W-1:0] prod_adj;
  logic signed [15:0]       trig_sat;
  logic                     div_start;
  logic signed [DIV_W-1:0]  div_num;
  logic [15:0]              div_den;
  logic                     div_busy;
  logic                     div_done;
  logic signed [DIV_W-1:0]  div_q;

  assign len      = (len_r == 16'd0) ? 16'd1 : len_r;
  assign bcnt_inc = bcnt_r + 16'd1;
  assign go       = active_r || (s_r > start_r);
  assign wr_idx   = head_r + fill_r[WIN_IDX_W-1:0];
  assign hc_inc   = hc_r + 20'd1;

  always_comb begin
    if (int'(kept_r) > WIN_DEPTH) begin
      keep = WIN_CNT_W'(WIN_DEPTH);
    end else if (kept_r == 7'd0) begin
      keep = WIN_CNT_W'(1);
    end else begin
      keep = WIN_CNT_W'(kept_r);
    end
  end

  // Scale by Q8.8 factor: arithmetic shift, then round a negative toward zero
  assign prod_shr = prod_r >>> 8;
  assign prod_adj = prod_shr + PROD_W'((prod_r < 0) && (prod_r[7:0] != 8'd0));

  always_comb begin
    if (prod_adj > PROD_W'(32'sd32767)) begin
      trig_sat = 16'sh7fff;
    end else if (prod_adj < PROD_W'(-32'sd32768)) begin
      trig_sat = 16'sh8000;
    end else begin
      trig_sat = prod_adj[15:0];
    end
  end

  // Shared divider: block average, then window mean
  assign div_start = cmd.div_avg || cmd.div_mean;
  assign div_num   = cmd.div_mean ? DIV_W'(wsum_r) : DIV_W'(bsum_r);
  assign div_den   = cmd.div_mean ? 16'(fill_r) : len;

  apd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= START_THR_RST;
      len_r       <= BLOCK_LEN_RST;
      kept_r      <= AVG_KEPT_RST;
      hold_r      <= HOLD_RST;
      factor_r    <= FACTOR_RST;
      active_r    <= 1'b0;
      bcnt_r      <= '0;
      bsum_r      <= '0;
      fill_r      <= '0;
      head_r      <= '0;
      wsum_r      <= '0;
      trig_r      <= START_THR_RST;
      holding_r   <= 1'b0;
      hc_r        <= '0;
      close_due_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_THRESHOLD:  start_r  <= cfg_wdata[15:0];
          CFG_BLOCK_LENGTH:     len_r    <= cfg_wdata[15:0];
          CFG_AVERAGES_KEPT:    kept_r   <= cfg_wdata[6:0];
          CFG_HOLD_SAMPLES:     hold_r   <= cfg_wdata[19:0];
          CFG_DETECTION_FACTOR: factor_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end

      priority if (cmd.eval) begin
        if (op_r == OP_REARM) begin
          active_r <= 1'b0;
          fill_r   <= '0;
          head_r   <= '0;
          wsum_r   <= '0;
        end else if (go) begin
          active_r    <= 1'b1;
          bsum_r      <= bsum_r + 32'(s_r);
          bcnt_r      <= bcnt_inc;
          close_due_r <= bcnt_inc >= len;
        end
      end else if (cmd.drop) begin
        wsum_r <= wsum_r - WSUM_W'($signed(rd_data_r));
        head_r <= head_r + 1'b1;
        fill_r <= fill_r - 1'b1;
      end else if (cmd.push) begin
        wsum_r <= wsum_r + WSUM_W'(avg_r);
        fill_r <= fill_r + 1'b1;
        bcnt_r <= '0;
        bsum_r <= '0;
      end else if (cmd.sat) begin
        trig_r <= trig_sat;
      end else if (cmd.hold_step) begin
        if (holding_r) begin
          if (hc_inc >= hold_r) begin
            hc_r      <= '0;
            holding_r <= 1'b0;
          end else begin
            hc_r <= hc_inc;
          end
        end else if (s_r > trig_r) begin
          holding_r <= 1'b1;
        end
      end else begin
      end

      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r <= in_op;
      s_r  <= in_sample;
    end
    if (cmd.eval) begin
      res_peak_r <= 1'b0;
      res_det_r  <= (op_r != OP_REARM) && go;
    end
    if (cmd.hold_step) begin
      res_peak_r <= !holding_r && (s_r > trig_r);
    end
    if (cmd.take_avg) begin
      avg_r <= div_q[AVG_W-1:0];
    end
    if (cmd.take_mean) begin
      mean_r <= div_q[AVG_W-1:0];
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(mean_r) * PROD_W'($signed({1'b0, factor_r}));
    end
    if (cmd.load_out) begin
      out_peak_r <= res_peak_r;
      out_det_r  <= res_det_r;
    end
  end

  // Window store: one write port, one registered read at the oldest entry
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      win_mem[wr_idx] <= avg_r;
    end
    rd_data_r <= win_mem[head_r];
  end

  assign sts.rearm     = (op_r == OP_REARM);
  assign sts.go        = go;
  assign sts.close_due = close_due_r;
  assign sts.div_done  = div_done;
  assign sts.div_busy  = div_busy;
  assign sts.drop_due  = fill_r >= keep;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_peak      = out_peak_r;
  assign out_detecting = out_det_r;

endmodule

/* sv/apd_ctrl.sv */
// ----------------------------------------------------------------------------
// Adaptive peak detector controller
// Sequences one item at a time through evaluate, block close and hold check.
// ----------------------------------------------------------------------------
module apd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output apd_pkg::apd_cmd_t cmd,
  input  apd_pkg::apd_sts_t sts
);
  import apd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_CHECK,
    S_DIVA,
    S_DROPCHK,
    S_DROPSUB,
    S_PUSH,
    S_MSTART,
    S_DIVM,
    S_MUL,
    S_SAT,
    S_HOLD,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.latch_in = in_valid;
        if (in_valid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = (sts.rearm || !sts.go) ? S_EMIT : S_CHECK;
      end
      S_CHECK: begin
        cmd.div_avg = sts.close_due;
        state_nxt   = sts.close_due ? S_DIVA : S_HOLD;
      end
      S_DIVA: begin
        cmd.take_avg = sts.div_done;
        if (sts.div_done) state_nxt = S_DROPCHK;
      end
      S_DROPCHK: begin
        state_nxt = sts.drop_due ? S_DROPSUB : S_PUSH;
      end
      S_DROPSUB: begin
        cmd.drop  = 1'b1;
        state_nxt = S_DROPCHK;
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = S_MSTART;
      end
      S_MSTART: begin
        cmd.div_mean = 1'b1;
        state_nxt    = S_DIVM;
      end
      S_DIVM: begin
        cmd.take_mean = sts.div_done;
        if (sts.div_done) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SAT;
      end
      S_SAT: begin
        cmd.sat   = 1'b1;
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        cmd.hold_step = 1'b1;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        cmd.load_out = sts.out_free;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

/* sv/adaptive_peak_detector_unit.sv */
// ----------------------------------------------------------------------------
// Adaptive peak detector unit
// Onset detector with a trigger level that tracks the recent signal average.
// ----------------------------------------------------------------------------
// Takes one signed Q1.15 sample per transfer (op 0) or a rearm (op 1) and
// returns exactly one result per item: peak and detecting. Items are handled
// one at a time. A rearm or a sample before detection starts goes from
// evaluate straight to the result; a detecting sample that does not close
// a block passes the hold check first. A sample that closes a block runs
// the shared 38-step divider twice (block average, then window mean) plus
// a multiply and saturate step, and drops old window entries before the
// push (one once the window is full, more only right after averages_kept
// is lowered). The result sits in an output register, so a new item is
// taken while it waits. The window store needs no clearing pass after reset.
// Configuration registers may be written only while the block is idle.
// ----------------------------------------------------------------------------
module adaptive_peak_detector_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  apd_in_if.sink                         in_ch,
  apd_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [apd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import apd_pkg::*;

  `include "adaptive_peak_detector_unit_assert.svh"

  apd_cmd_t cmd;
  apd_sts_t sts;
  logic     in_ready;

  // Sequencer: one item in flight, steps the datapath through its phases
  apd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Datapath: accumulate, window, divide, scale, hold and the result register
  apd_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_op         (in_ch.op),
    .in_sample     (in_ch.sample),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_peak      (out_ch.peak),
    .out_detecting (out_ch.detecting)
  );

  assign in_ch.ready = in_ready;

  // Only one item in flight: ready drops right after a transfer
  `APD_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  // Divider is never restarted while still iterating
  `APD_ASSERT_SAME(a_div_idle_on_start, clk, rst_n, cmd.div_avg || cmd.div_mean, !sts.div_busy)
  // A result never overwrites one that has not been taken
  `APD_ASSERT_SAME(a_no_result_overrun, clk, rst_n, cmd.load_out, sts.out_free)

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// Adaptive peak detector unit testbench
// Drives sample and rearm transfers with random gaps, predicts the peak and
// detecting flags from its own model of the block, and checks every result.
// ----------------------------------------------------------------------------
module tb;
  import apd_pkg::*;

  // Hold-off length of the long result stall, and settle times.
  localparam int     LONG_STALL   = 300;
  localparam int     SETTLE_CYCLES = 10;
  localparam int     TAIL_CYCLES  = 250;
  localparam longint RUN_LIMIT    = 64'd16_000_000;

  typedef struct packed {
    logic               op;
    logic signed [15:0] sample;
  } sample_item_t;

  typedef struct packed {
    logic peak;
    logic detecting;
  } onset_flags_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  apd_in_if  in_ch ();
  apd_out_if out_ch ();

  adaptive_peak_detector_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow of the block: register copies and detector state
  // --------------------------------------------------------------------------
  logic signed [15:0] start_level;
  logic [15:0]        block_len;
  logic [6:0]         keep_max;
  logic [19:0]        hold_len;
  logic [15:0]        gain;

  logic               detect_on;
  logic [15:0]        blk_count;
  longint             blk_sum;
  longint             avg_ring [WIN_DEPTH];
  int                 ring_fill;
  int                 ring_head;
  longint             ring_sum;
  logic signed [15:0] trig_level;
  logic               in_hold;
  logic [19:0]        hold_count;

  // Stimulus, expectations and bookkeeping
  sample_item_t items_to_send [$];
  onset_flags_t flags_due [$];
  bit  steady;          // no idle gaps on either side while set
  bit  in_took, out_took;
  int  tx_wait, rx_wait;
  int  stall_reqs, stall_done, stall_left;
  int  errors, n_sent, n_rearms, n_checked, n_peaks, blocks_closed, settings_run;

  // Advance the shadow detector by one item and return the flags it gives.
  function automatic onset_flags_t track_onset(input logic op,
                                               input logic signed [15:0] s);
    onset_flags_t r;
    int unsigned  len;
    int           keep;
    longint       avg, mean, prod;
    r = '0;
    if (op == OP_REARM) begin
      // Rearm drops detection and empties the window; block and hold carry on.
      detect_on = 1'b0;
      ring_fill = 0;
      ring_head = 0;
      ring_sum  = 0;
      return r;
    end
    if (detect_on || s > start_level) begin
      len = (block_len == 16'd0) ? 1 : block_len;
      detect_on = 1'b1;
      blk_sum += longint'(s);
      blk_count = blk_count + 16'd1;
      // Close the block once the count reaches or passes the length.
      if (blk_count >= len) begin
        keep = (keep_max == 7'd0) ? 1 : ((keep_max > WIN_DEPTH) ? WIN_DEPTH : keep_max);
        avg = blk_sum / longint'(len);
        while (ring_fill >= keep) begin
          ring_sum -= avg_ring[ring_head];
          ring_head = (ring_head + 1) % WIN_DEPTH;
          ring_fill--;
        end
        avg_ring[(ring_head + ring_fill) % WIN_DEPTH] = avg;
        ring_fill++;
        ring_sum += avg;
        mean = ring_sum / longint'(ring_fill);
        prod = (mean * longint'(gain)) / 256;
        if (prod > 32767) prod = 32767;
        else if (prod < -32768) prod = -32768;
        trig_level = prod[15:0];
        blk_count = '0;
        blk_sum = 0;
        blocks_closed++;
      end
      // A sample inside the hold only counts it down; it is never a peak.
      if (in_hold) begin
        hold_count = hold_count + 20'd1;
        if (hold_count >= hold_len) begin
          hold_count = '0;
          in_hold = 1'b0;
        end
      end else if (s > trig_level) begin
        r.peak = 1'b1;
        in_hold = 1'b1;
      end
    end
    r.detecting = detect_on;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Rising edge: check result transfers, predict input transfers
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    onset_flags_t want;
    if (!rst_n) begin
      in_took  <= 1'b0;
      out_took <= 1'b0;
    end else begin
      // Check first: a result can never stem from an item taken this edge.
      if (out_ch.valid && out_ch.ready) begin
        if (flags_due.size() == 0) begin
          $error("unexpected result: peak %0b detecting %0b", out_ch.peak, out_ch.detecting);
          errors++;
        end else begin
          want = flags_due.pop_front();
          if (out_ch.peak !== want.peak) begin
            $error("peak: expected %0b, actual %0b", want.peak, out_ch.peak);
            errors++;
          end
          if (out_ch.detecting !== want.detecting) begin
            $error("detecting: expected %0b, actual %0b", want.detecting, out_ch.detecting);
            errors++;
          end
          n_checked++;
          if (want.peak) n_peaks++;
        end
      end
      if (in_ch.valid && in_ch.ready)
        flags_due.push_back(track_onset(in_ch.op, in_ch.sample));
      in_took  <= in_ch.valid && in_ch.ready;
      out_took <= out_ch.valid && out_ch.ready;
    end
  end

  // --------------------------------------------------------------------------
  // Falling edge: sender offers the next queued item after its drawn gap
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : sample_source
    sample_item_t cur;
    if (rst_n && (!in_ch.valid || in_took)) begin
      if (tx_wait > 0) begin
        tx_wait--;
        in_ch.valid <= 1'b0;
      end else if (items_to_send.size() != 0) begin
        cur = items_to_send.pop_front();
        in_ch.op     <= cur.op;
        in_ch.sample <= cur.sample;
        in_ch.valid  <= 1'b1;
        tx_wait = steady ? 0 : $urandom_range(0, 3);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Falling edge: receiver readiness, with gaps and the long hold-off
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : result_sink
    if (rst_n) begin
      if (out_took) rx_wait = steady ? 0 : $urandom_range(0, 3);
      if (stall_done != stall_reqs) begin
        stall_done++;
        stall_left = LONG_STALL;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Queue one item for the sender.
  task automatic send(input logic op, input logic signed [15:0] s);
    sample_item_t it;
    it.op = op;
    it.sample = s;
    items_to_send.push_back(it);
    n_sent++;
    if (op == OP_REARM) n_rearms++;
  endtask

  // Write one register while the block is idle, and mirror it in the shadow.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_START_THRESHOLD:  start_level = val[15:0];
      CFG_BLOCK_LENGTH:     block_len   = val[15:0];
      CFG_AVERAGES_KEPT:    keep_max    = val[6:0];
      CFG_HOLD_SAMPLES:     hold_len    = val;
      CFG_DETECTION_FACTOR: gain        = val[15:0];
      default: ;
    endcase
  endtask

  // Hold the sequencer until every queued item is through and answered.
  task automatic drain();
    while (items_to_send.size() != 0 || in_ch.valid || flags_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    settings_run++;
  endtask

  // --------------------------------------------------------------------------
  // Sequencer: directed checks, then random phases with fresh settings
  // --------------------------------------------------------------------------
  initial begin
    int                 p, k, pick, base, amp, v, n_items;
    logic signed [15:0] thr;
    logic [15:0]        len, fac;
    logic [6:0]         keep;
    logic [19:0]        hold;

    rst_n = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.op     = OP_SAMPLE;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    steady = 1'b0;

    // Shadow state after reset
    start_level = START_THR_RST;
    block_len   = BLOCK_LEN_RST;
    keep_max    = AVG_KEPT_RST;
    hold_len    = HOLD_RST;
    gain        = FACTOR_RST;
    detect_on   = 1'b0;
    blk_count   = '0;
    blk_sum     = 0;
    ring_fill   = 0;
    ring_head   = 0;
    ring_sum    = 0;
    trig_level  = START_THR_RST;
    in_hold     = 1'b0;
    hold_count  = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: below, at and just above the start level, then rearm.
    send(OP_SAMPLE, 16'sd0);
    send(OP_SAMPLE, 16'sh8000);
    send(OP_SAMPLE, 16'sd3277);
    send(OP_SAMPLE, 16'sd3278);
    send(OP_SAMPLE, 16'sh7FFF);
    send(OP_SAMPLE, 16'sh8000);
    send(OP_REARM,  16'sh7FFF);
    send(OP_SAMPLE, 16'sd100);
    send(OP_SAMPLE, 16'sh7FFF);
    drain();

    // Lowest settings: zero length closes every sample, zero hold, zero factor.
    write_reg(CFG_START_THRESHOLD,  {4'b0, 16'sh8000});
    write_reg(CFG_BLOCK_LENGTH,     20'd0);
    write_reg(CFG_AVERAGES_KEPT,    20'd0);
    write_reg(CFG_HOLD_SAMPLES,     20'd0);
    write_reg(CFG_DETECTION_FACTOR, 20'd0);
    send(OP_REARM,  16'sd0);
    send(OP_SAMPLE, 16'sh8000);
    send(OP_SAMPLE, -16'sd32767);
    send(OP_SAMPLE, 16'sd5);
    send(OP_SAMPLE, 16'sd1);
    send(OP_SAMPLE, 16'sd0);
    send(OP_SAMPLE, 16'sh7FFF);
    send(OP_SAMPLE, -16'sd1);
    drain();

    // Highest settings: a start level nothing exceeds, the longest block and
    // hold, a window size above the store depth and the largest factor.
    write_reg(CFG_START_THRESHOLD,  {4'b0, 16'sh7FFF});
    write_reg(CFG_BLOCK_LENGTH,     20'd65535);
    write_reg(CFG_AVERAGES_KEPT,    20'd127);
    write_reg(CFG_HOLD_SAMPLES,     20'hFFFFF);
    write_reg(CFG_DETECTION_FACTOR, 20'd65535);
    send(OP_SAMPLE, 16'sh7FFF);
    send(OP_SAMPLE, 16'sh7FFF);
    send(OP_SAMPLE, 16'sh7FFF);
    send(OP_SAMPLE, 16'sh8000);
    send(OP_SAMPLE, 16'sd20000);
    drain();

    // Shorten the block under a running count: it closes on the next sample,
    // and the huge factor drives the trigger level into saturation.
    write_reg(CFG_BLOCK_LENGTH, 20'd2);
    send(OP_SAMPLE, 16'sd100);
    send(OP_SAMPLE, 16'sh8000);
    send(OP_SAMPLE, 16'sh8000);
    drain();

    // Random phases. Phase 2 fills the whole window one sample per block and
    // phase 3 shrinks it, so many stale averages are dropped at once. Phase 5
    // runs without gaps under a long result stall to back up the input.
    for (p = 0; p < 12; p++) begin
      if (p % 3 == 0) thr = 16'($urandom);
      else thr = 16'($urandom_range(0, 6000) - 1000);

      pick = $urandom_range(0, 99);
      if (p == 2) len = 16'd1;
      else if (pick < 75) len = 16'($urandom_range(1, 6));
      else if (pick < 87) len = 16'd0;
      else len = 16'($urandom_range(7, 60));

      pick = $urandom_range(0, 99);
      if (p == 2) keep = 7'd64;
      else if (p == 3) keep = 7'd2;
      else if (pick < 80) keep = 7'($urandom_range(1, 64));
      else keep = 7'($urandom_range(0, 127));

      pick = $urandom_range(0, 99);
      if (pick < 85) hold = 20'($urandom_range(0, 10));
      else if (pick < 95) hold = 20'($urandom_range(11, 1000));
      else hold = 20'($urandom_range(0, 20'hFFFFF));

      if ($urandom_range(0, 99) < 70) fac = 16'($urandom_range(128, 2048));
      else fac = 16'($urandom);

      write_reg(CFG_START_THRESHOLD,  {4'b0, thr});
      write_reg(CFG_BLOCK_LENGTH,     {4'b0, len});
      write_reg(CFG_AVERAGES_KEPT,    {13'b0, keep});
      write_reg(CFG_HOLD_SAMPLES,     hold);
      write_reg(CFG_DETECTION_FACTOR, {4'b0, fac});

      steady = (p % 4 == 1);
      if (p == 5) stall_reqs++;
      n_items = (p == 2) ? 80 : 64;
      base = int'($urandom_range(0, 3000)) - 500;
      amp  = $urandom_range(0, 2000);

      // Mostly a noisy level around a drifting base with spikes on top;
      // the rest is full-range noise, rail values and the odd rearm.
      for (k = 0; k < n_items; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3 && p != 2) begin
          send(OP_REARM, 16'($urandom));
        end else if (pick < 60) begin
          v = base + int'($urandom_range(0, 2 * amp)) - amp;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          send(OP_SAMPLE, 16'(v));
        end else if (pick < 80) begin
          v = $urandom_range(4000, 32767);
          if ($urandom_range(0, 1)) v = -v;
          send(OP_SAMPLE, 16'(v));
        end else if (pick < 95) begin
          send(OP_SAMPLE, 16'($urandom));
        end else begin
          send(OP_SAMPLE, $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000);
        end
      end
      drain();
    end
    steady = 1'b0;

    // Let any stray result surface before closing.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (flags_due.size() != 0) begin
      $error("%0d expected results never arrived", flags_due.size());
      errors++;
    end

    $display("Run covered %0d items (%0d rearms) under %0d register settings; %0d results checked.",
             n_sent, n_rearms, settings_run, n_checked);
    $display("The detector flagged %0d peaks and pushed %0d block averages into its window.",
             n_peaks, blocks_closed);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #(RUN_LIMIT);
    $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/apd_pkg.sv
sv/apd_channels.sv
sv/apd_div.sv
sv/apd_dp.sv
sv/apd_ctrl.sv
sv/adaptive_peak_detector_unit.sv
bench/tb.sv
